// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the hash set RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held
`define CHS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hash set check failed");

// Clocked check that also holds during reset
`define CHS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("hash set check failed");

`endif

// ===== rtl/chs_pkg.sv =====
// ---------------------------------------------------------------------------
// chs_pkg: shared types and constants of the chained hash set
// Opcodes, status codes, controller states and default sizes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package chs_pkg;

  localparam int unsigned BUCKETS_DEF    = 1024;
  localparam int unsigned POOL_NODES_DEF = 1024;
  localparam int unsigned KEY_BITS_DEF   = 32;

  localparam int unsigned MOD_BITS   = 11;
  localparam int unsigned CNT_BITS   = 11;
  localparam logic [MOD_BITS-1:0] MOD_RESET = 11'd1021;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_HEAD,
    S_LOAD,
    S_WALK,
    S_CMP,
    S_UPDATE,
    S_RESP
  } state_t;

endpackage

// ===== rtl/chs_ram.sv =====
// ---------------------------------------------------------------------------
// chs_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module chs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/chs_bucket.sv =====
// ---------------------------------------------------------------------------
// chs_bucket: bucket index unit
// Restoring division of the key magnitude, one quotient bit per cycle;
// the remainder is folded to a non-negative bucket for negative keys.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module chs_bucket import chs_pkg::*; #(
  parameter int unsigned BUCKETS  = BUCKETS_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [KEY_BITS-1:0]        key,
  input  logic [MOD_BITS-1:0]        modulus,
  output logic                       done,
  output logic [$clog2(BUCKETS)-1:0] bucket
);

  localparam int unsigned CB = $clog2(BUCKETS + 1);
  localparam int unsigned MW = (CB > MOD_BITS) ? CB : MOD_BITS;
  localparam int unsigned BI = $clog2(BUCKETS);
  localparam int unsigned CW = $clog2(KEY_BITS + 1);

  logic              busy_r, busy_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [KEY_BITS-1:0] dvd_r, dvd_nxt;
  logic [MW-1:0]     rem_r, rem_nxt;
  logic [MW-1:0]     m_r, m_nxt;
  logic              neg_r, neg_nxt;
  logic [MW-1:0]     m_clamp;
  logic [MW:0]       trial;
  logic [MW-1:0]     folded;

  // clamp the modulus into 2..BUCKETS
  always_comb begin
    m_clamp = MW'(modulus);
    if (m_clamp < MW'(2)) begin
      m_clamp = MW'(2);
    end else if (m_clamp > MW'(BUCKETS)) begin
      m_clamp = MW'(BUCKETS);
    end
  end

  assign trial = {rem_r, dvd_r[KEY_BITS-1]};

  // one restoring step per cycle
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    m_nxt    = m_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(KEY_BITS);
      dvd_nxt  = key[KEY_BITS-1] ? (~key + 1'b1) : key;
      rem_nxt  = '0;
      m_nxt    = m_clamp;
      neg_nxt  = key[KEY_BITS-1];
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (trial >= {1'b0, m_r}) begin
          rem_nxt = MW'(trial - {1'b0, m_r});
        end else begin
          rem_nxt = MW'(trial);
        end
        dvd_nxt = dvd_r << 1;
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    m_r   <= m_nxt;
    neg_r <= neg_nxt;
  end

  // negative keys with a non-zero remainder map to m - r
  assign folded = (neg_r && rem_r != '0) ? (m_r - rem_r) : rem_r;
  assign done   = busy_r && (cnt_r == '0);
  assign bucket = BI'(folded);

  `CHS_ASSERT(a_bucket_range, clk, rst_n, done |-> (folded < m_r))
  `CHS_ASSERT(a_no_restart, clk, rst_n, start |-> !busy_r)

endmodule

// ===== rtl/chained_hash_set_core.sv =====
// ---------------------------------------------------------------------------
// chained_hash_set_core: hash set of signed keys with separate chaining
// Bucket heads, node keys, node links and the free stack live in RAMs.
// ---------------------------------------------------------------------------
// After reset the block sweeps the bucket head RAM, one entry a cycle, and
// takes no item meanwhile (register writes are taken). An item then passes
// through the bit-serial bucket divider, reads the bucket head, reads and
// compares the key/link RAM entries node by node along the chain, writes
// back to the RAMs for insert and delete and hands over the result. The
// unused opcode skips the divider and the chain walk. One item is in work at
// a time; the result register lets the next item in while a result waits to
// be taken.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module chained_hash_set_core import chs_pkg::*; #(
  parameter int unsigned BUCKETS    = BUCKETS_DEF,
  parameter int unsigned POOL_NODES = POOL_NODES_DEF,
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_opcode,
  input  logic signed [KEY_BITS-1:0] in_key,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [CNT_BITS-1:0] out_compare_count,
  output logic [CNT_BITS-1:0] out_entry_count,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned PW = $clog2(POOL_NODES + 1);
  localparam int unsigned NI = $clog2(POOL_NODES);
  localparam int unsigned BI = $clog2(BUCKETS);

  // configuration register
  logic [MOD_BITS-1:0] modulus_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(modulus_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_RESET;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      modulus_r <= pwdata[MOD_BITS-1:0];
    end
  end

  // controller state
  state_t           state_r, state_nxt;
  logic [BI-1:0]    clr_r, clr_nxt;
  op_t              op_r, op_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [BI-1:0]    bucket_r, bucket_nxt;
  logic [PW-1:0]    head_r, head_nxt;
  logic [PW-1:0]    cur_r, cur_nxt;
  logic [PW-1:0]    prev_r, prev_nxt;
  logic [PW-1:0]    node_r, node_nxt;
  logic [PW-1:0]    nlink_r, nlink_nxt;
  logic             found_r, found_nxt;
  logic [PW-1:0]    n_r, n_nxt;
  logic [PW-1:0]    fdepth_r, fdepth_nxt;
  logic [PW-1:0]    mark_r, mark_nxt;
  logic [PW-1:0]    count_r, count_nxt;
  status_t          res_status_r, res_status_nxt;
  logic [PW-1:0]    res_cmp_r, res_cmp_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [CNT_BITS-1:0] out_cmp_r, out_cmp_nxt;
  logic [CNT_BITS-1:0] out_cnt_r, out_cnt_nxt;

  // RAM ports
  logic            h_we;
  logic [BI-1:0]   h_waddr;
  logic [PW-1:0]   h_wdata, h_q;
  logic            k_we;
  logic [NI-1:0]   k_waddr;
  logic [KEY_BITS-1:0] k_q;
  logic            l_we;
  logic [NI-1:0]   l_waddr;
  logic [PW-1:0]   l_wdata, l_q;
  logic            f_we;
  logic [NI-1:0]   f_waddr, f_wdata, f_q;
  logic [NI-1:0]   node_raddr;
  logic [NI-1:0]   slot;

  logic            div_start, div_done;
  logic [BI-1:0]   div_bucket;

  // divider takes the key straight from the input beat
  chs_bucket #(
    .BUCKETS  (BUCKETS),
    .KEY_BITS (KEY_BITS)
  ) u_bucket (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .key     (in_key),
    .modulus (modulus_r),
    .done    (div_done),
    .bucket  (div_bucket)
  );

  chs_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_heads (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(bucket_r), .rdata(h_q)
  );

  chs_ram #(.WIDTH(KEY_BITS), .DEPTH(POOL_NODES)) u_keys (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(key_r),
    .raddr(node_raddr), .rdata(k_q)
  );

  chs_ram #(.WIDTH(PW), .DEPTH(POOL_NODES)) u_links (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(node_raddr), .rdata(l_q)
  );

  chs_ram #(.WIDTH(NI), .DEPTH(POOL_NODES)) u_free (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(NI'(fdepth_r - 1'b1)), .rdata(f_q)
  );

  // chain nodes are addressed by pointer minus one
  assign node_raddr = NI'(cur_r - 1'b1);
  assign in_ready   = (state_r == S_IDLE);
  // the unused opcode needs no bucket
  assign div_start  = (state_r == S_IDLE) && in_valid && (op_t'(in_opcode) != OP_NONE);

  // next state, RAM write-back and result
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    bucket_nxt     = bucket_r;
    head_nxt       = head_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    node_nxt       = node_r;
    nlink_nxt      = nlink_r;
    found_nxt      = found_r;
    n_nxt          = n_r;
    fdepth_nxt     = fdepth_r;
    mark_nxt       = mark_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_cmp_nxt    = res_cmp_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_cmp_nxt    = out_cmp_r;
    out_cnt_nxt    = out_cnt_r;
    h_we    = 1'b0;
    h_waddr = bucket_r;
    h_wdata = '0;
    k_we    = 1'b0;
    k_waddr = '0;
    l_we    = 1'b0;
    l_waddr = '0;
    l_wdata = nlink_r;
    f_we    = 1'b0;
    f_waddr = NI'(fdepth_r);
    f_wdata = NI'(node_r - 1'b1);
    slot    = '0;

    case (state_r)
      // sweep the bucket heads to empty
      S_CLEAR: begin
        h_we    = 1'b1;
        h_waddr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BI'(BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = op_t'(in_opcode);
          key_nxt   = in_key;
          prev_nxt  = '0;
          found_nxt = 1'b0;
          n_nxt     = '0;
          state_nxt = (op_t'(in_opcode) == OP_NONE) ? S_UPDATE : S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          bucket_nxt = div_bucket;
          state_nxt  = S_HEAD;
        end
      end
      S_HEAD: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        head_nxt  = h_q;
        cur_nxt   = h_q;
        state_nxt = S_WALK;
      end
      // stop at chain end or after a pool's worth of nodes
      S_WALK: begin
        if (cur_r == '0 || n_r == PW'(POOL_NODES)) begin
          state_nxt = S_UPDATE;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        n_nxt = n_r + 1'b1;
        if (k_q == key_r) begin
          found_nxt = 1'b1;
          node_nxt  = cur_r;
          nlink_nxt = l_q;
          state_nxt = S_UPDATE;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = l_q;
          state_nxt = S_WALK;
        end
      end
      S_UPDATE: begin
        res_status_nxt = ST_OK;
        res_cmp_nxt    = '0;
        case (op_r)
          OP_INSERT: begin
            if (found_r) begin
              res_status_nxt = ST_DUP;
            end else if (fdepth_r != '0 || mark_r < PW'(POOL_NODES)) begin
              if (fdepth_r != '0) begin
                slot       = f_q;
                fdepth_nxt = fdepth_r - 1'b1;
              end else begin
                slot     = NI'(mark_r);
                mark_nxt = mark_r + 1'b1;
              end
              k_we      = 1'b1;
              k_waddr   = slot;
              l_we      = 1'b1;
              l_waddr   = slot;
              l_wdata   = head_r;
              h_we      = 1'b1;
              h_wdata   = PW'(slot) + 1'b1;
              count_nxt = count_r + 1'b1;
            end else begin
              res_status_nxt = ST_FULL;
            end
          end
          OP_SEARCH: begin
            res_cmp_nxt = n_r;
            if (!found_r) begin
              res_status_nxt = ST_MISSING;
            end
          end
          OP_DELETE: begin
            if (!found_r) begin
              res_status_nxt = ST_MISSING;
            end else begin
              if (prev_r == '0) begin
                h_we    = 1'b1;
                h_wdata = nlink_r;
              end else begin
                l_we    = 1'b1;
                l_waddr = NI'(prev_r - 1'b1);
              end
              if (fdepth_r < PW'(POOL_NODES)) begin
                f_we       = 1'b1;
                fdepth_nxt = fdepth_r + 1'b1;
              end
              if (count_r != '0) begin
                count_nxt = count_r - 1'b1;
              end
            end
          end
          default: begin
            res_status_nxt = ST_OK;
          end
        endcase
        state_nxt = S_RESP;
      end
      // hand the result to the output register once it is free
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_cmp_nxt    = CNT_BITS'(res_cmp_r);
          out_cnt_nxt    = CNT_BITS'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      fdepth_r    <= '0;
      mark_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      fdepth_r    <= fdepth_nxt;
      mark_r      <= mark_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    bucket_r     <= bucket_nxt;
    head_r       <= head_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    node_r       <= node_nxt;
    nlink_r      <= nlink_nxt;
    found_r      <= found_nxt;
    n_r          <= n_nxt;
    res_status_r <= res_status_nxt;
    res_cmp_r    <= res_cmp_nxt;
    out_status_r <= out_status_nxt;
    out_cmp_r    <= out_cmp_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_compare_count = out_cmp_r;
  assign out_entry_count   = out_cnt_r;

  // every node taken from the pool is either held or on the free stack
  `CHS_ASSERT(a_pool_balance, clk, rst_n, (count_r + fdepth_r) == mark_r)
  `CHS_ASSERT(a_mark_bound, clk, rst_n, mark_r <= PW'(POOL_NODES))
  // a beat leaves the result register only from a finished item
  `CHS_ASSERT(a_resp_load, clk, rst_n,
    (state_r == S_RESP && state_nxt == S_IDLE) |=> out_valid_r)
  `CHS_ASSERT_ALWAYS(a_no_accept_in_reset, clk, !rst_n |=> !in_ready)

endmodule
